FILE: hw/rtl/i2cm_pkg.sv
// i2cm_pkg: shared types and constants for the i2c master byte controller
// no dependencies; imported by the interfaces and every rtl module
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

   // bus commands carried in func
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   // completion status codes
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_NO_ACK    = 2'd1;
   localparam logic [1:0] STS_BUS_BUSY  = 2'd2;
   localparam logic [1:0] STS_START_ERR = 2'd3;

   // phase timer reset value
   localparam logic [15:0] PHASE_RESET = 16'd5;

   // one input word: a bus tick with optional command
   typedef struct packed {
      logic [2:0] func;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } req_data_type;

   // one result word
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] rx_byte;
      logic       cmd_rejected;
   } rsp_data_type;

endpackage

`default_nettype wire

FILE: hw/rtl/i2cm_if.sv
// i2cm_if: valid/ready channel interfaces for request and response words
// depends on i2cm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_req_if
   import i2cm_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic [7:0] tx_byte;
   logic       send_ack;
   logic       sda_in;

   modport source (output valid, output func, output tx_byte, output send_ack,
                   output sda_in, input ready);
   modport sink   (input valid, input func, input tx_byte, input send_ack,
                   input sda_in, output ready);
endinterface

interface i2cm_rsp_if
   import i2cm_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       busy_res;
   logic       done_res;
   logic [1:0] status;
   logic [7:0] rx_byte;
   logic       cmd_rejected;

   modport source (output valid, output scl_level, output sda_level, output busy_res,
                   output done_res, output status, output rx_byte,
                   output cmd_rejected, input ready);
   modport sink   (input valid, input scl_level, input sda_level, input busy_res,
                   input done_res, input status, input rx_byte,
                   input cmd_rejected, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/i2c_master_byte_controller.sv
// i2c_master_byte_controller: an accepted request word goes into the input register, then
// through the sequencer logic into the output register, which holds its response word.
// One word per cycle unless rsp_ch stalls; the sequencer state updates once per word.
// Synchronous active-high reset: bus lines released high, sequencer idle, status ok,
// phase_ticks back to 5, both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_controller
   import i2cm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   i2cm_req_if.sink         req_ch,
   i2cm_rsp_if.source       rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);

   logic          in_vld_ff,  in_vld_in;
   req_data_type  in_data_ff;
   logic          out_vld_ff, out_vld_in;
   rsp_data_type  out_data_ff;
   logic [15:0]   phase_ff;
   logic          advance;
   logic          req_fire;
   logic          tick_fire;
   req_data_type  req_word;
   rsp_data_type  core_result;

   // pipeline flow control
   assign advance      = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = !in_vld_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign tick_fire    = in_vld_ff && advance;
   assign in_vld_in    = req_fire || (in_vld_ff && !advance);
   assign out_vld_in   = advance ? in_vld_ff : out_vld_ff;

   assign req_word.func     = req_ch.func;
   assign req_word.tx_byte  = req_ch.tx_byte;
   assign req_word.send_ack = req_ch.send_ack;
   assign req_word.sda_in   = req_ch.sda_in;

   // phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_RESET;
      end else if (csr_we) begin
         phase_ff <= csr_wdata;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_word;
      end
   end

   // sequencer
   i2cm_core u_core (
      .clock       (clock),
      .reset       (reset),
      .tick_fire   (tick_fire),
      .tick_data   (in_data_ff),
      .phase_ticks (phase_ff),
      .result      (core_result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_fire) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.scl_level    = out_data_ff.scl_level;
   assign rsp_ch.sda_level    = out_data_ff.sda_level;
   assign rsp_ch.busy_res     = out_data_ff.busy_res;
   assign rsp_ch.done_res     = out_data_ff.done_res;
   assign rsp_ch.status       = out_data_ff.status;
   assign rsp_ch.rx_byte      = out_data_ff.rx_byte;
   assign rsp_ch.cmd_rejected = out_data_ff.cmd_rejected;

endmodule

`default_nettype wire

FILE: hw/rtl/i2cm_core.sv
// i2cm_core: command sequencer state and per-tick next-state / result logic
// depends on i2cm_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cm_core
   import i2cm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          tick_fire,
   input  wire req_data_type  tick_data,
   input  wire logic [15:0]   phase_ticks,
   output      rsp_data_type  result
);

   logic [2:0]  cmd_ff,    cmd_in;
   logic [2:0]  step_ff,   step_in;
   logic [15:0] tick_ff,   tick_in;
   logic [3:0]  bitc_ff,   bitc_in;
   logic [7:0]  shift_ff,  shift_in;
   logic        ack_ff,    ack_in;
   logic [1:0]  status_ff, status_in;
   logic        scl_ff,    scl_in;
   logic        sda_ff,    sda_in;
   logic [7:0]  rx_ff,     rx_in;
   logic        rejected;
   logic        done;
   logic [15:0] period_m1;
   logic        last_tick;

   // zero phase behaves as one tick
   assign period_m1 = (phase_ticks == 16'd0) ? 16'd0 : phase_ticks - 16'd1;

   // next state for one tick
   always_comb begin
      cmd_in    = cmd_ff;
      step_in   = step_ff;
      tick_in   = tick_ff;
      bitc_in   = bitc_ff;
      shift_in  = shift_ff;
      ack_in    = ack_ff;
      status_in = status_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      rx_in     = rx_ff;
      rejected  = 1'b0;
      done      = 1'b0;
      last_tick = 1'b0;

      // command launch or rejection
      if (cmd_ff == CMD_NONE) begin
         if (tick_data.func >= CMD_START && tick_data.func <= CMD_READ) begin
            cmd_in   = tick_data.func;
            step_in  = 3'd0;
            tick_in  = 16'd0;
            bitc_in  = 4'd0;
            shift_in = (tick_data.func == CMD_WRITE) ? tick_data.tx_byte : 8'd0;
            if (tick_data.func == CMD_READ) begin
               ack_in = tick_data.send_ack;
            end
         end
      end else if (tick_data.func != CMD_NONE) begin
         rejected = 1'b1;
      end

      if (cmd_in != CMD_NONE) begin
         // line changes on the first tick of a step
         if (tick_in == 16'd0) begin
            case (cmd_in)
               CMD_START: begin
                  if (step_in == 3'd0) begin
                     scl_in = 1'b1;
                     sda_in = 1'b1;
                  end else begin
                     sda_in = 1'b0;
                  end
               end
               CMD_STOP: begin
                  if (step_in == 3'd0)      scl_in = 1'b0;
                  else if (step_in == 3'd1) sda_in = 1'b0;
                  else if (step_in == 3'd2) scl_in = 1'b1;
                  else                      sda_in = 1'b1;
               end
               CMD_WRITE: begin
                  if (step_in == 3'd0 || step_in == 3'd3 || step_in == 3'd6) scl_in = 1'b0;
                  else if (step_in == 3'd1) sda_in = shift_in[7];
                  else if (step_in == 3'd4) sda_in = 1'b1;
                  else                      scl_in = 1'b1;
               end
               CMD_READ: begin
                  if (step_in == 3'd0) begin
                     scl_in = 1'b0;
                     sda_in = 1'b1;
                  end else if (step_in == 3'd1 || step_in == 3'd4) begin
                     scl_in = 1'b1;
                  end else if (step_in == 3'd2 || step_in == 3'd5) begin
                     scl_in = 1'b0;
                  end else begin
                     sda_in = ~ack_in;
                  end
               end
               default: begin
               end
            endcase
         end

         // end of step: sample and advance
         last_tick = (tick_in >= period_m1);
         if (last_tick) begin
            tick_in = 16'd0;
            case (cmd_in)
               CMD_START: begin
                  if (step_in == 3'd0 && !tick_data.sda_in) begin
                     status_in = STS_BUS_BUSY;
                     done      = 1'b1;
                  end else if (step_in == 3'd1 && tick_data.sda_in) begin
                     status_in = STS_START_ERR;
                     done      = 1'b1;
                  end else if (step_in >= 3'd2) begin
                     status_in = STS_OK;
                     done      = 1'b1;
                  end else begin
                     step_in = step_in + 3'd1;
                  end
               end
               CMD_STOP: begin
                  if (step_in >= 3'd3) begin
                     status_in = STS_OK;
                     done      = 1'b1;
                  end else begin
                     step_in = step_in + 3'd1;
                  end
               end
               CMD_WRITE: begin
                  if (step_in == 3'd2) begin
                     shift_in = {shift_in[6:0], 1'b0};
                     bitc_in  = bitc_in + 4'd1;
                     step_in  = (bitc_in >= 4'd8) ? 3'd3 : 3'd0;
                  end else if (step_in == 3'd5) begin
                     status_in = tick_data.sda_in ? STS_NO_ACK : STS_OK;
                     step_in   = 3'd6;
                  end else if (step_in >= 3'd6) begin
                     done = 1'b1;
                  end else begin
                     step_in = step_in + 3'd1;
                  end
               end
               CMD_READ: begin
                  if (step_in == 3'd1) begin
                     shift_in = {shift_in[6:0], tick_data.sda_in};
                     bitc_in  = bitc_in + 4'd1;
                     step_in  = (bitc_in >= 4'd8) ? 3'd2 : 3'd0;
                  end else if (step_in >= 3'd5) begin
                     rx_in     = shift_in;
                     status_in = STS_OK;
                     done      = 1'b1;
                  end else begin
                     step_in = step_in + 3'd1;
                  end
               end
               default: begin
                  status_in = STS_OK;
                  done      = 1'b1;
               end
            endcase
            // finished command returns to idle
            if (done) begin
               cmd_in  = CMD_NONE;
               step_in = 3'd0;
            end
         end else begin
            tick_in = tick_in + 16'd1;
         end
      end
   end

   // result word for this tick
   always_comb begin
      result.scl_level    = scl_in;
      result.sda_level    = sda_in;
      result.busy_res     = (cmd_in != CMD_NONE);
      result.done_res     = done;
      result.status       = status_in;
      result.rx_byte      = rx_in;
      result.cmd_rejected = rejected;
   end

   // sequencer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff    <= CMD_NONE;
         step_ff   <= 3'd0;
         tick_ff   <= 16'd0;
         bitc_ff   <= 4'd0;
         shift_ff  <= 8'd0;
         ack_ff    <= 1'b0;
         status_ff <= STS_OK;
         scl_ff    <= 1'b1;
         sda_ff    <= 1'b1;
         rx_ff     <= 8'd0;
      end else if (tick_fire) begin
         cmd_ff    <= cmd_in;
         step_ff   <= step_in;
         tick_ff   <= tick_in;
         bitc_ff   <= bitc_in;
         shift_ff  <= shift_in;
         ack_ff    <= ack_in;
         status_ff <= status_in;
         scl_ff    <= scl_in;
         sda_ff    <= sda_in;
         rx_ff     <= rx_in;
      end
   end

endmodule

`default_nettype wire
